>>> src/lru_tag_pkg.sv
package lru_tag_pkg;

    // Fixed field widths
    localparam int ADDR_WIDTH  = 48;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int SET_BITS_W  = 3;
    localparam int WAYS_W      = 4;
    localparam int OFFSET_W    = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    // Access kinds; the unused code behaves as a load
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [ADDR_WIDTH-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         hits_added;
        logic               missed;
        logic               evicted;
        logic [COUNT_W-1:0] total_hits;
        logic [COUNT_W-1:0] total_misses;
        logic [COUNT_W-1:0] total_evictions;
    } out_item_t;

    // One way of a set
    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
    } line_t;

    // Outcome of one lookup, handed from the update logic to the top level
    typedef struct packed {
        logic [1:0] hits_added;
        logic       missed;
        logic       evicted;
    } upd_status_t;

endpackage

>>> src/lru_tag_update.sv
module lru_tag_update #(
    parameter int MAX_WAYS = 8,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int CNT_W = $clog2(MAX_WAYS + 1)
) (
    input  lru_tag_pkg::line_t [MAX_WAYS-1:0]     row,
    input  logic [lru_tag_pkg::ADDR_WIDTH-1:0]    lookup_tag,
    input  logic [lru_tag_pkg::MODE_W-1:0]        mode,
    input  logic [CNT_W-1:0]                      ways,
    output lru_tag_pkg::line_t [MAX_WAYS-1:0]     new_row,
    output lru_tag_pkg::upd_status_t              status
);
    import lru_tag_pkg::*;

    logic [MAX_WAYS-1:0] hit_vec;
    logic                hit;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    last_idx;
    line_t               moved;
    logic                is_modify;

    // Compare every way in use, pick the most recent match
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            hit_vec[i] = (i < int'(ways)) && row[i].valid && (row[i].tag == lookup_tag);
        end
        hit = |hit_vec;
        hit_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = WAY_W'(i);
            end
        end
    end

    // Rotate the chosen way to the front; a miss takes the least recent way in use
    always_comb begin
        last_idx = hit ? hit_idx : WAY_W'(ways - 1'b1);
        moved = hit ? row[last_idx] : line_t'{valid: 1'b1, tag: lookup_tag};
        new_row = row;
        new_row[0] = moved;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (i <= int'(last_idx)) begin
                new_row[i] = row[i-1];
            end
        end
    end

    // Per-access outcome; a modify always adds one hit for its store half
    always_comb begin
        is_modify = (mode == MODE_MODIFY);
        status.missed = !hit;
        status.evicted = !hit && row[last_idx].valid;
        if (hit) begin
            status.hits_added = is_modify ? 2'd2 : 2'd1;
        end else begin
            status.hits_added = is_modify ? 2'd1 : 2'd0;
        end
    end

endmodule

>>> src/lru_set_assoc_cache_tag_sim.sv
// Set-associative cache tag simulator with true LRU replacement.
// Input channel (s_valid/s_ready/s_payload): one access per transfer, a mode
// (load, store, modify) and a byte address. Result channel (m_valid/m_ready/
// m_payload): one result per access, in order, with the access outcome and the
// saturating running totals of hits, misses and evictions.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write it only while no access is in flight.
// An access is registered into the lookup stage at the input transfer; its result is
// loaded into the result register when that stage advances. Throughput: one access per
// cycle while results drain and no clearing pass runs. The tag store is one row per set with
// one read and one write port; a lookup reads its row at the input transfer and writes the
// reordered row back when the lookup stage advances. An access to the same set that enters
// as that row is written takes it from a bypass register. Reset: counters clear, registers
// return to 0/1/0, then a clearing pass writes every set invalid in turn with s_ready low.
// Stall: when m_ready is low and a result waits, an access in the lookup stage holds and
// s_ready drops until the result register drains.
module lru_set_assoc_cache_tag_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lru_tag_pkg::in_item_t                s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lru_tag_pkg::out_item_t               m_payload,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lru_tag_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lru_tag_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lru_tag_pkg::*;

    localparam int SET_W    = MAX_SET_BITS;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);

    // Configuration
    logic [SET_BITS_W-1:0] set_index_bits_reg;
    logic [WAYS_W-1:0]     ways_in_use_reg;
    logic [OFFSET_W-1:0]   block_offset_bits_reg;

    // Decode of the incoming access
    logic [SET_BITS_W-1:0] set_bits_eff;
    logic [CNT_W-1:0]      ways_eff;
    logic [ADDR_WIDTH-1:0] addr_shr;
    logic [SET_W-1:0]      s_set;
    logic [ADDR_WIDTH-1:0] s_tag;
    logic                  s_fire;

    // Lookup stage
    logic                  busy_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [SET_W-1:0]      set_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic                  adv;

    // Tag store and its bypass
    line_t [MAX_WAYS-1:0]  tag_store_mem [NUM_SETS];
    line_t [MAX_WAYS-1:0]  rd_row_reg;
    line_t [MAX_WAYS-1:0]  fwd_row_reg;
    logic                  fwd_reg;
    line_t [MAX_WAYS-1:0]  cur_row;
    line_t [MAX_WAYS-1:0]  new_row;
    upd_status_t           status;
    logic                  wr_en;
    logic [SET_W-1:0]      wr_addr;
    line_t [MAX_WAYS-1:0]  wr_data;

    // Clearing pass
    logic                  clearing_reg;
    logic [SET_W-1:0]      clr_idx_reg;

    // Counters and result register
    logic [COUNT_W-1:0]    hit_cnt_reg;
    logic [COUNT_W-1:0]    miss_cnt_reg;
    logic [COUNT_W-1:0]    evict_cnt_reg;
    logic [COUNT_W-1:0]    hit_cnt_next;
    logic [COUNT_W-1:0]    miss_cnt_next;
    logic [COUNT_W-1:0]    evict_cnt_next;
    logic [COUNT_W:0]      hit_sum;
    logic [COUNT_W:0]      miss_sum;
    logic [COUNT_W:0]      evict_sum;
    logic                  m_valid_reg;
    out_item_t             m_payload_reg;

    // Handshakes
    assign adv       = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clearing_reg && (!busy_reg || adv);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_index_bits_reg    <= '0;
            ways_in_use_reg       <= WAYS_W'(1);
            block_offset_bits_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SET_INDEX_BITS:    set_index_bits_reg    <= cfg_data[SET_BITS_W-1:0];
                CFG_WAYS_IN_USE:       ways_in_use_reg       <= cfg_data[WAYS_W-1:0];
                CFG_BLOCK_OFFSET_BITS: block_offset_bits_reg <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp configuration and split the address into set and tag
    always_comb begin
        set_bits_eff = (int'(set_index_bits_reg) > MAX_SET_BITS) ?
                       SET_BITS_W'(MAX_SET_BITS) : set_index_bits_reg;
        if (ways_in_use_reg == '0) begin
            ways_eff = CNT_W'(1);
        end else if (int'(ways_in_use_reg) > MAX_WAYS) begin
            ways_eff = CNT_W'(MAX_WAYS);
        end else begin
            ways_eff = CNT_W'(ways_in_use_reg);
        end
        addr_shr = s_payload.address >> block_offset_bits_reg;
        s_set = addr_shr[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits_eff);
        s_tag = s_payload.address >>
                ({1'b0, block_offset_bits_reg} + {{(OFFSET_W + 1 - SET_BITS_W){1'b0}},
                                                  set_bits_eff});
    end

    // Hold the access in the lookup stage until its result moves out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_fire) begin
            busy_reg <= 1'b1;
        end else if (adv) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg <= s_payload.mode;
            set_reg  <= s_set;
            tag_reg  <= s_tag;
        end
    end

    // Pick the write: clearing pass first, then the reordered row
    always_comb begin
        wr_en   = clearing_reg || adv;
        wr_addr = clearing_reg ? clr_idx_reg : set_reg;
        wr_data = clearing_reg ? '0 : new_row;
    end

    // Tag store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_store_mem[wr_addr] <= wr_data;
        end
        if (s_fire) begin
            rd_row_reg <= tag_store_mem[s_set];
        end
    end

    // Bypass the row being written when the next access hits the same set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (s_fire) begin
            fwd_reg <= adv && (set_reg == s_set);
        end else if (adv) begin
            fwd_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fwd_row_reg <= new_row;
        end
    end

    assign cur_row = fwd_reg ? fwd_row_reg : rd_row_reg;

    lru_tag_update #(
        .MAX_WAYS (MAX_WAYS)
    ) u_update (
        .row        (cur_row),
        .lookup_tag (tag_reg),
        .mode       (mode_reg),
        .ways       (ways_eff),
        .new_row    (new_row),
        .status     (status)
    );

    // Sweep every set to invalid after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == {SET_W{1'b1}}) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Saturating running totals
    always_comb begin
        hit_sum   = {1'b0, hit_cnt_reg} + (COUNT_W + 1)'(status.hits_added);
        miss_sum  = {1'b0, miss_cnt_reg} + (COUNT_W + 1)'(status.missed);
        evict_sum = {1'b0, evict_cnt_reg} + (COUNT_W + 1)'(status.evicted);
        hit_cnt_next   = hit_sum[COUNT_W] ? {COUNT_W{1'b1}} : hit_sum[COUNT_W-1:0];
        miss_cnt_next  = miss_sum[COUNT_W] ? {COUNT_W{1'b1}} : miss_sum[COUNT_W-1:0];
        evict_cnt_next = evict_sum[COUNT_W] ? {COUNT_W{1'b1}} : evict_sum[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end else if (adv) begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    // Load the result register; drop valid once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_payload_reg.hits_added      <= status.hits_added;
            m_payload_reg.missed          <= status.missed;
            m_payload_reg.evicted         <= status.evicted;
            m_payload_reg.total_hits      <= hit_cnt_next;
            m_payload_reg.total_misses    <= miss_cnt_next;
            m_payload_reg.total_evictions <= evict_cnt_next;
        end
    end

    // A finished lookup always shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_valid)
        else $error("finished lookup did not reach the result register");

    // The bypass is armed only for an access that sits in the lookup stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> busy_reg)
        else $error("bypass armed with the lookup stage empty");

    // An eviction only comes with a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.evicted |-> m_payload.missed)
        else $error("eviction reported without a miss");

    // A miss never adds two hits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.missed |-> m_payload.hits_added != 2'd2)
        else $error("miss reported with two hits");

    // Totals never go down between resets
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (hit_cnt_reg >= $past(hit_cnt_reg)) &&
                           (miss_cnt_reg >= $past(miss_cnt_reg)) &&
                           (evict_cnt_reg >= $past(evict_cnt_reg)))
        else $error("running total decreased");

endmodule

>>> sim/lru_tag_sim_checker.sv
module lru_tag_sim_checker #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  lru_tag_pkg::in_item_t                s_payload,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  lru_tag_pkg::out_item_t               m_payload,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [lru_tag_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lru_tag_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                   mismatch_count,
    output int                                   results_pending
);
    import lru_tag_pkg::*;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;

    // Shadow tag store, ways of each set kept most recent first
    line_t tag_store [NUM_SETS][MAX_WAYS];

    logic [COUNT_W-1:0]    hit_total;
    logic [COUNT_W-1:0]    miss_total;
    logic [COUNT_W-1:0]    evict_total;
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    out_item_t expected_results [$];

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] total, logic [1:0] add);
        logic [COUNT_W:0] sum;
        sum = total + add;
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    // Look one access up in the shadow store, update LRU order and totals
    function automatic out_item_t access_cache(in_item_t acc);
        out_item_t             res;
        int                    sbits;
        int                    nways;
        int                    set_idx;
        int                    hit_way;
        int                    last;
        logic [ADDR_WIDTH-1:0] tag;
        line_t                 moved;

        res = '0;
        sbits = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
        if (ways_reg == 0)
            nways = 1;
        else if (ways_reg > MAX_WAYS)
            nways = MAX_WAYS;
        else
            nways = int'(ways_reg);

        // Shifts past the address width read as zero
        set_idx = int'((acc.address >> offset_reg) & ((48'd1 << sbits) - 48'd1));
        set_idx = set_idx & (NUM_SETS - 1);
        tag = acc.address >> (int'(offset_reg) + sbits);

        hit_way = nways;
        for (int w = 0; w < nways; w++) begin
            if (tag_store[set_idx][w].valid && tag_store[set_idx][w].tag == tag) begin
                hit_way = w;
                break;
            end
        end

        // Rotate the hit way, or the least recent one, to the front
        last = (hit_way < nways) ? hit_way : nways - 1;
        moved = tag_store[set_idx][last];
        for (int i = last; i > 0; i--)
            tag_store[set_idx][i] = tag_store[set_idx][i-1];
        tag_store[set_idx][0] = moved;

        if (hit_way < nways) begin
            res.hits_added = (acc.mode == MODE_MODIFY) ? 2'd2 : 2'd1;
        end else begin
            res.evicted = moved.valid;
            res.missed = 1'b1;
            res.hits_added = (acc.mode == MODE_MODIFY) ? 2'd1 : 2'd0;
            tag_store[set_idx][0].valid = 1'b1;
            tag_store[set_idx][0].tag = tag;
        end

        hit_total = sat_inc(hit_total, res.hits_added);
        miss_total = sat_inc(miss_total, {1'b0, res.missed});
        evict_total = sat_inc(evict_total, {1'b0, res.evicted});
        res.total_hits = hit_total;
        res.total_misses = miss_total;
        res.total_evictions = evict_total;
        return res;
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Track config writes, predict each access, compare each result transfer
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int s = 0; s < NUM_SETS; s++)
                for (int w = 0; w < MAX_WAYS; w++)
                    tag_store[s][w] = '0;
            hit_total = '0;
            miss_total = '0;
            evict_total = '0;
            set_bits_reg = '0;
            ways_reg = 4'd1;
            offset_reg = '0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with none expected: total_hits %0d",
                           m_payload.total_hits);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hits_added", want.hits_added, m_payload.hits_added);
                    check_field("missed", want.missed, m_payload.missed);
                    check_field("evicted", want.evicted, m_payload.evicted);
                    check_field("total_hits", want.total_hits, m_payload.total_hits);
                    check_field("total_misses", want.total_misses, m_payload.total_misses);
                    check_field("total_evictions", want.total_evictions,
                                m_payload.total_evictions);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SET_INDEX_BITS:    set_bits_reg = cfg_data[SET_BITS_W-1:0];
                    CFG_WAYS_IN_USE:       ways_reg = cfg_data[WAYS_W-1:0];
                    CFG_BLOCK_OFFSET_BITS: offset_reg = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(access_cache(s_payload));
        end
        results_pending = expected_results.size();
    end

endmodule

>>> sim/lru_set_assoc_cache_tag_sim_tb.sv
module lru_set_assoc_cache_tag_sim_tb;
    import lru_tag_pkg::*;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 56;

    // Codes the package leaves unnamed: the spare access kind and register slot
    localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_payload;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_payload;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatch_count;
    int results_pending;
    int quiet_cycles = 0;
    bit src_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;

    lru_set_assoc_cache_tag_sim #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lru_tag_sim_checker #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_pending(results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result sink: stall in random bursts while enabled
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lru_set_assoc_cache_tag_sim: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one access, optionally after an idle burst; hold until transfer
    task automatic send_access(logic [MODE_W-1:0] mode, logic [ADDR_WIDTH-1:0] addr);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_payload = '{mode: mode, address: addr};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic quiesce();
        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
    endtask

    // Write the three geometry registers back to back, plus the spare slot if asked
    task automatic write_geometry(logic [CFG_DATA_W-1:0] sbits, logic [CFG_DATA_W-1:0] ways,
                                  logic [CFG_DATA_W-1:0] offset, bit poke_spare);
        logic [CFG_INDEX_W-1:0] regs [4];
        logic [CFG_DATA_W-1:0]  vals [4];
        regs = '{CFG_SET_INDEX_BITS, CFG_WAYS_IN_USE, CFG_BLOCK_OFFSET_BITS, CFG_SPARE};
        vals = '{sbits, ways, offset, CFG_DATA_W'($urandom())};
        cfg_valid = 1'b1;
        for (int i = 0; i < (poke_spare ? 4 : 3); i++) begin
            cfg_index = regs[i];
            cfg_data = vals[i];
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
    endtask

    // Mostly revisit a small working set of lines, with some stray addresses
    task automatic run_phase(int n_items, int pool_size, int offset);
        logic [ADDR_WIDTH-1:0] hot [$];
        logic [ADDR_WIDTH-1:0] block_mask;
        logic [ADDR_WIDTH-1:0] addr;
        block_mask = (48'd1 << offset) - 48'd1;
        for (int i = 0; i < pool_size; i++)
            hot.push_back({16'($urandom()), 32'($urandom())});
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 4) != 0)
                addr = hot[$urandom_range(0, pool_size - 1)]
                       ^ ({16'($urandom()), 32'($urandom())} & block_mask);
            else
                addr = {16'($urandom()), 32'($urandom())};
            send_access(MODE_W'($urandom_range(0, 3)), addr);
        end
    endtask

    initial begin
        int sbits;
        int ways;
        int offset;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SET_INDEX_BITS;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset geometry: one set, one way, so every new address after the first evicts
        send_access(MODE_LOAD, 48'h0);
        send_access(MODE_LOAD, 48'h1);

        // Two-way, four sets, 16-byte blocks: hits, modify, spare kind, LRU victim
        quiesce();
        write_geometry(6'd2, 6'd2, 6'd4, 1'b0);
        send_access(MODE_LOAD, 48'h0);
        send_access(MODE_STORE, 48'h0);
        send_access(MODE_MODIFY, 48'h0);
        send_access(MODE_SPARE, 48'h8);
        send_access(MODE_MODIFY, 48'h100);
        send_access(MODE_LOAD, 48'h200);
        send_access(MODE_LOAD, 48'h0);
        send_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
        send_access(MODE_STORE, 48'hFFFF_FFFF_FFFF);
        send_access(MODE_LOAD, 48'h8000_0000_0000);

        // Set bits clamp to the maximum, zero ways act as one, spare slot ignored
        quiesce();
        write_geometry(6'd7, 6'd0, 6'd40, 1'b1);
        send_access(MODE_LOAD, 48'hFFFF_FFFF_FFFF);
        send_access(MODE_STORE, 48'hFFFF_FFFF_FFFF);
        send_access(MODE_LOAD, 48'h7FFF_FFFF_FFFF);

        // Offset past the address: set and tag both collapse to zero
        quiesce();
        write_geometry(6'd6, 6'd15, 6'd63, 1'b0);
        send_access(MODE_LOAD, {16'($urandom()), 32'($urandom())});
        send_access(MODE_STORE, {16'($urandom()), 32'($urandom())});
        send_access(MODE_MODIFY, {16'($urandom()), 32'($urandom())});

        // Set field straddles the top of the address; ways above the maximum
        quiesce();
        write_geometry(6'd3, 6'd9, 6'd46, 1'b0);
        send_access(MODE_LOAD, 48'hC000_0000_0000);
        send_access(MODE_LOAD, 48'h4000_0000_0000);
        send_access(MODE_LOAD, 48'hC000_0000_0000);

        // Random phases; the store carries over between geometry changes
        for (int p = 0; p < NUM_PHASES; p++) begin
            quiesce();
            case (p)
                0: begin
                    sbits = 0;
                    ways = 1;
                    offset = 0;
                end
                1: begin
                    sbits = 6;
                    ways = 8;
                    offset = 42;
                end
                2: begin
                    sbits = 7;
                    ways = 15;
                    offset = $urandom_range(0, 63);
                end
                default: begin
                    sbits = $urandom_range(0, 7);
                    ways = $urandom_range(0, 15);
                    offset = $urandom_range(0, 44);
                end
            endcase
            src_gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stalls_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            write_geometry(CFG_DATA_W'(sbits), CFG_DATA_W'(ways), CFG_DATA_W'(offset), 1'b0);
            run_phase(PHASE_ITEMS, $urandom_range(2, 24), offset);
        end

        quiesce();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("lru_set_assoc_cache_tag_sim: match");
        else
            $display("lru_set_assoc_cache_tag_sim: mismatch");
        $finish;
    end

endmodule
